// ----- rtl/core/mrsp_pkg.sv -----
// shared types and constants for the multi-resource shelf packer
package mrsp_pkg;
  localparam int NUM_RES_DEF     = 4;
  localparam int MAX_SHELVES_DEF = 64;
  localparam int RES_W  = 16;
  localparam int TIME_W = 40;
  localparam int DUR_W  = 32;
  localparam int CNT_W  = 11;
  localparam int IDX_W  = 8;

  localparam logic [IDX_W-1:0] REG_MODE  = 8'd0;
  localparam logic [IDX_W-1:0] REG_CAP_0 = 8'd1;
  localparam logic [IDX_W-1:0] REG_CAP_1 = 8'd2;
  localparam logic [IDX_W-1:0] REG_CAP_2 = 8'd3;
  localparam logic [IDX_W-1:0] REG_CAP_3 = 8'd4;

  typedef logic [3:0][RES_W-1:0] res_vec_t;

  typedef struct packed {
    logic              valid;
    logic              ff;
    logic              found;
    logic [CNT_W-1:0]  open;
    logic [CNT_W-1:0]  tgt;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] makespan;
    res_vec_t          dem;
  } tok_t;
endpackage

// ----- rtl/core/mrsp_if.sv -----
// channel interfaces for tasks, results and configuration writes
interface mrsp_task_if;
  logic        valid;
  logic        ready;
  logic        new_schedule;
  logic [15:0] task_id;
  logic [31:0] task_time;
  logic [15:0] demand_0;
  logic [15:0] demand_1;
  logic [15:0] demand_2;
  logic [15:0] demand_3;
  modport source (output valid, new_schedule, task_id, task_time,
                  demand_0, demand_1, demand_2, demand_3, input ready);
  modport sink (input valid, new_schedule, task_id, task_time,
                demand_0, demand_1, demand_2, demand_3, output ready);
endinterface

interface mrsp_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_task_id;
  logic [39:0] start_time;
  logic [39:0] makespan;
  logic        shelves_full;
  logic        demand_too_large;
  modport source (output valid, out_task_id, start_time, makespan, shelves_full,
                  demand_too_large, input ready);
  modport sink (input valid, out_task_id, start_time, makespan, shelves_full,
                demand_too_large, output ready);
endinterface

interface mrsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/mrsp_cell.sv -----
// one shelf cell: holds remaining capacity and start of a shelf
module mrsp_cell #(
  parameter int IDX     = 0,
  parameter int NUM_RES = mrsp_pkg::NUM_RES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  mrsp_pkg::res_vec_t cap,
  input  mrsp_pkg::tok_t    tok_in,
  output mrsp_pkg::tok_t    tok_out
);
  localparam logic [mrsp_pkg::CNT_W-1:0] MY_IDX = mrsp_pkg::CNT_W'(IDX);

  mrsp_pkg::res_vec_t              rem;
  logic [mrsp_pkg::TIME_W-1:0]     start;
  logic                            fits;
  logic                            use_me;
  logic                            open_me;

  always_comb begin
    fits = 1'b1;
    for (int r = 0; r < NUM_RES; r++) begin
      if (tok_in.dem[r] > rem[r]) fits = 1'b0;
    end
  end

  always_comb begin
    use_me  = 1'b0;
    open_me = 1'b0;
    if (tok_in.valid && !tok_in.found) begin
      if (tok_in.ff) begin
        use_me  = (MY_IDX < tok_in.open) && fits;
        open_me = (MY_IDX == tok_in.open);
      end else if (MY_IDX == tok_in.tgt) begin
        use_me  = (tok_in.open != '0) && fits;
        open_me = !use_me;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.ff       <= tok_in.ff;
    tok_out.open     <= tok_in.open;
    tok_out.tgt      <= tok_in.tgt;
    tok_out.makespan <= tok_in.makespan;
    tok_out.dem      <= tok_in.dem;
    tok_out.found    <= tok_in.found | use_me;
    tok_out.start    <= use_me ? start : tok_in.start;
    if (use_me) begin
      for (int r = 0; r < NUM_RES; r++) rem[r] <= rem[r] - tok_in.dem[r];
    end else if (open_me) begin
      start <= tok_in.makespan;
      for (int r = 0; r < NUM_RES; r++) begin
        rem[r] <= (tok_in.dem[r] > cap[r]) ? '0 : cap[r] - tok_in.dem[r];
      end
    end
  end
endmodule

// ----- rtl/core/multi_resource_shelf_packer.sv -----
// Shelf packer top level. Shelves live in a chain of MAX_SHELVES cells, and
// each task walks the chain one cell per cycle. A task is taken in IDLE,
// walks the chain in RUN, and its result is loaded into the output register
// in DONE, in both modes; the next task is taken at the earliest at the first
// edge at which the prior result beat can be taken. One task is in flight at
// a time; a result may wait in the output register while the next task walks
// the chain. Configuration writes are always taken.
module multi_resource_shelf_packer #(
  parameter int NUM_RES     = mrsp_pkg::NUM_RES_DEF,
  parameter int MAX_SHELVES = mrsp_pkg::MAX_SHELVES_DEF
) (
  input logic          clk,
  input logic          rst,
  mrsp_task_if.sink    in_ch,
  mrsp_result_if.source out_ch,
  mrsp_cfg_if.sink     cfg
);
  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

  localparam logic [mrsp_pkg::CNT_W-1:0] MAX_CNT = mrsp_pkg::CNT_W'(MAX_SHELVES);

  state_t                          state;
  logic                            ff_mode;
  mrsp_pkg::res_vec_t              cap;
  logic [mrsp_pkg::CNT_W-1:0]      open;
  logic [mrsp_pkg::TIME_W-1:0]     mk;
  logic [mrsp_pkg::DUR_W-1:0]      dur;
  logic [15:0]                     tid;
  logic                            too_large;
  mrsp_pkg::tok_t                  chain [MAX_SHELVES+1];
  mrsp_pkg::tok_t                  head;
  mrsp_pkg::res_vec_t              dem_in;
  logic [mrsp_pkg::CNT_W-1:0]      open_eff;
  logic [mrsp_pkg::TIME_W-1:0]     mk_eff;
  logic [mrsp_pkg::TIME_W:0]       mk_sum;
  logic                            tl_in;
  logic [15:0]                     p_id;
  logic [mrsp_pkg::TIME_W-1:0]     p_start;
  logic [mrsp_pkg::TIME_W-1:0]     p_mk;
  logic                            p_full;
  logic                            p_tl;
  mrsp_pkg::tok_t                  tail;

  assign cfg.ready   = 1'b1;
  assign in_ch.ready = (state == IDLE);
  assign tail        = chain[MAX_SHELVES];

  always_comb begin
    dem_in = '0;
    dem_in[0] = in_ch.demand_0;
    if (NUM_RES > 1) dem_in[1] = in_ch.demand_1;
    if (NUM_RES > 2) dem_in[2] = in_ch.demand_2;
    if (NUM_RES > 3) dem_in[3] = in_ch.demand_3;
    tl_in = 1'b0;
    for (int r = 0; r < NUM_RES; r++) begin
      if (dem_in[r] > cap[r]) tl_in = 1'b1;
    end
    open_eff = in_ch.new_schedule ? '0 : open;
    mk_eff   = in_ch.new_schedule ? '0 : mk;
    head          = '0;
    head.valid    = in_ch.valid && in_ch.ready;
    head.ff       = ff_mode;
    head.open     = open_eff;
    head.tgt      = (open_eff == '0) ? '0 : open_eff - 1'b1;
    head.makespan = mk_eff;
    head.dem      = dem_in;
    mk_sum = {1'b0, mk} + {{(mrsp_pkg::TIME_W+1-mrsp_pkg::DUR_W){1'b0}}, dur};
  end

  assign chain[0] = head;

  for (genvar k = 0; k < MAX_SHELVES; k++) begin : g_cell
    mrsp_cell #(.IDX(k), .NUM_RES(NUM_RES)) u_cell (
      .clk(clk), .rst(rst), .cap(cap), .tok_in(chain[k]), .tok_out(chain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      ff_mode      <= 1'b0;
      cap          <= '0;
      open         <= '0;
      mk           <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          mrsp_pkg::REG_MODE:  ff_mode <= cfg.data[0];
          mrsp_pkg::REG_CAP_0: cap[0]  <= cfg.data;
          mrsp_pkg::REG_CAP_1: cap[1]  <= cfg.data;
          mrsp_pkg::REG_CAP_2: cap[2]  <= cfg.data;
          mrsp_pkg::REG_CAP_3: cap[3]  <= cfg.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready && state != DONE) out_ch.valid <= 1'b0;
      case (state)
        IDLE: begin
          if (in_ch.valid) begin
            open      <= open_eff;
            mk        <= mk_eff;
            dur       <= in_ch.task_time;
            tid       <= in_ch.task_id;
            too_large <= tl_in;
            state     <= RUN;
          end
        end
        RUN: begin
          if (tail.valid) begin
            p_id   <= tid;
            p_tl   <= too_large;
            p_full <= 1'b0;
            if (tail.found) begin
              p_start <= tail.start;
              p_mk    <= mk;
            end else begin
              p_start <= mk;
              p_mk    <= mk_sum[mrsp_pkg::TIME_W] ? '1 : mk_sum[mrsp_pkg::TIME_W-1:0];
              mk      <= mk_sum[mrsp_pkg::TIME_W] ? '1 : mk_sum[mrsp_pkg::TIME_W-1:0];
              if (tail.ff) begin
                if (open < MAX_CNT) open <= open + 1'b1;
                else p_full <= 1'b1;
              end else if (open == '0) begin
                open <= open + 1'b1;
              end
            end
            state <= DONE;
          end
        end
        DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid            <= 1'b1;
            out_ch.out_task_id      <= p_id;
            out_ch.start_time       <= p_start;
            out_ch.makespan         <= p_mk;
            out_ch.shelves_full     <= p_full;
            out_ch.demand_too_large <= p_tl;
            state                   <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/core/mrsp_checker.sv -----
// port-level checks for the shelf packer, bound to the top level
module mrsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [39:0] out_makespan,
  input logic [39:0] out_start
);
  a_one_task: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("task taken while another is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_makespan))
    else $error("stalled result beat changed");

  a_start_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_start <= out_makespan)
    else $error("start beyond makespan");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat after reset");
endmodule

bind multi_resource_shelf_packer mrsp_checker u_mrsp_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_makespan(out_ch.makespan), .out_start(out_ch.start_time)
);
